// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent, suspended while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache checker: property failed");

// Same, but also checked while reset is applied.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cache checker: property failed");

`endif

// File: hw/rtl/salc_pkg.sv
// Shared constants, codes and control types of the LRU cache model.
`default_nettype none
package salc_pkg;

   // field widths
   localparam int ACTION_W     = 2;
   localparam int ADDRESS_W    = 64;
   localparam int OUTCOME_W    = 2;
   localparam int TOTAL_W      = 32;
   localparam int STAMP_W      = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 6;
   localparam int SET_CFG_W    = 3;
   localparam int OFFSET_CFG_W = 6;
   localparam int WAYS_CFG_W   = 4;
   localparam int SBITS_W      = 4;   // effective set bits, up to 7
   localparam int SHIFT_W      = 7;   // offset + set bits, up to 70

   // action codes; anything but modify is a single lookup
   localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS        = 2'd2;

   // register reset values
   localparam logic [SET_CFG_W-1:0]    RST_SET_BITS    = 3'd4;
   localparam logic [OFFSET_CFG_W-1:0] RST_OFFSET_BITS = 6'd4;
   localparam logic [WAYS_CFG_W-1:0]   RST_WAYS        = 4'd1;

   typedef struct packed {
      logic clear;    // clear one row of valid bits
      logic accept;   // take request, start set read
      logic eval;     // register tag matches and ages
      logic commit;   // write back set, load first result
      logic second;   // load the second (hit) result of a modify
   } salc_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
      logic modify;
   } salc_sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/salc_req_if.sv
// Request channel: action and address.
`default_nettype none
interface salc_req_if;
   import salc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [ADDRESS_W-1:0] address;
   modport source (output valid, action, address, input ready);
   modport sink   (input valid, action, address, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/salc_rsp_if.sv
// Response channel: lookup outcome and running totals.
`default_nettype none
interface salc_rsp_if;
   import salc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 last;
   logic [TOTAL_W-1:0]   hit_total;
   logic [TOTAL_W-1:0]   miss_total;
   logic [TOTAL_W-1:0]   eviction_total;
   modport source (output valid, outcome, last, hit_total, miss_total, eviction_total,
                   input ready);
   modport sink   (input valid, outcome, last, hit_total, miss_total, eviction_total,
                   output ready);
endinterface
`default_nettype wire

// File: hw/rtl/salc_csr_if.sv
// Configuration write channel: register index and data.
`default_nettype none
interface salc_csr_if;
   import salc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: hw/rtl/salc_ctrl.sv
// Sequencer: clear pass, then accept / evaluate / commit per request, plus a second result for modify.
`default_nettype none
module salc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      salc_pkg::salc_cmd_type ctl_cmd,
   input  wire salc_pkg::salc_sts_type ctl_sts
);
   import salc_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_EVAL   = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_SECOND = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      ctl_cmd   = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctl_cmd.clear = 1'b1;
            if (ctl_sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.accept = 1'b1;
               state_in       = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctl_cmd.eval = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (ctl_sts.out_free) begin
               ctl_cmd.commit = 1'b1;
               state_in       = ctl_sts.modify ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (ctl_sts.out_free) begin
               ctl_cmd.second = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/salc_dpath.sv
// Datapath: config registers, address split, set memories, LRU pick, counters.
`default_nettype none
module salc_dpath #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire salc_pkg::salc_cmd_type                ctl_cmd,
   output      salc_pkg::salc_sts_type                ctl_sts,
   input  wire logic [salc_pkg::ACTION_W-1:0]         req_action,
   input  wire logic [salc_pkg::ADDRESS_W-1:0]        req_address,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [salc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]       csr_data,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [salc_pkg::OUTCOME_W-1:0]        rsp_outcome,
   output      logic                                  rsp_last,
   output      logic [salc_pkg::TOTAL_W-1:0]          rsp_hit_total,
   output      logic [salc_pkg::TOTAL_W-1:0]          rsp_miss_total,
   output      logic [salc_pkg::TOTAL_W-1:0]          rsp_eviction_total
);
   import salc_pkg::*;

   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W = $clog2(MAX_WAYS + 1);
   localparam int NP     = 1 << WAY_W;
   localparam int TAG_W  = ADDR_WIDTH;

   // ---------------- configuration registers ----------------
   logic [SET_CFG_W-1:0]    cfg_sbits_ff;
   logic [OFFSET_CFG_W-1:0] cfg_off_ff;
   logic [WAYS_CFG_W-1:0]   cfg_ways_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sbits_ff <= RST_SET_BITS;
         cfg_off_ff   <= RST_OFFSET_BITS;
         cfg_ways_ff  <= RST_WAYS;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SET_BITS:    cfg_sbits_ff <= csr_data[SET_CFG_W-1:0];
            CSR_OFFSET_BITS: cfg_off_ff   <= csr_data[OFFSET_CFG_W-1:0];
            CSR_WAYS:        cfg_ways_ff  <= csr_data[WAYS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- address split ----------------
   logic [ADDR_WIDTH-1:0] addr;
   logic [SBITS_W-1:0]    sbits_eff;
   logic [ADDR_WIDTH-1:0] off_shift;
   logic [SET_AW-1:0]     set_mask;
   logic [SET_AW-1:0]     set_idx;
   logic [SHIFT_W-1:0]    tag_shift;
   logic [TAG_W-1:0]      tag_val;
   logic [WCNT_W-1:0]     ways_eff;
   logic [MAX_WAYS-1:0]   way_use;

   assign addr      = req_address[ADDR_WIDTH-1:0];
   assign sbits_eff = (int'(cfg_sbits_ff) > MAX_SET_BITS) ? SBITS_W'(MAX_SET_BITS)
                                                         : SBITS_W'(cfg_sbits_ff);
   assign off_shift = addr >> cfg_off_ff;
   assign set_mask  = ~({SET_AW{1'b1}} << sbits_eff);
   assign set_idx   = off_shift[SET_AW-1:0] & set_mask;
   assign tag_shift = SHIFT_W'(cfg_off_ff) + SHIFT_W'(sbits_eff);
   assign tag_val   = addr >> tag_shift;

   always_comb begin
      if (cfg_ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(cfg_ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(cfg_ways_ff);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_use[w] = (int'(ways_eff) > w);
      end
   end

   // ---------------- request registers ----------------
   logic [SET_AW-1:0]   set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [MAX_WAYS-1:0] use_ff;
   logic [STAMP_W-1:0]  clock_ff;

   always_ff @(posedge clock) begin
      if (ctl_cmd.accept) begin
         set_ff    <= set_idx;
         tag_ff    <= tag_val;
         action_ff <= req_action;
         use_ff    <= way_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
      end else if (ctl_cmd.accept) begin
         clock_ff <= clock_ff + STAMP_W'(1);
      end
   end

   // ---------------- clear pass over valid rows ----------------
   logic [SET_AW-1:0] clr_cnt_ff;
   logic              clr_last;

   assign clr_last = (clr_cnt_ff == SET_AW'(SETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctl_cmd.clear && !clr_last) begin
         clr_cnt_ff <= clr_cnt_ff + SET_AW'(1);
      end
   end

   // ---------------- set memories ----------------
   logic [MAX_WAYS-1:0]         valid_rd, valid_new, valid_wr;
   logic [MAX_WAYS*TAG_W-1:0]   tag_rd, tag_new;
   logic [MAX_WAYS*STAMP_W-1:0] stamp_rd, stamp_new;
   logic [SET_AW-1:0]           wr_set;

   assign wr_set   = ctl_cmd.clear ? clr_cnt_ff : set_ff;
   assign valid_wr = ctl_cmd.clear ? '0 : valid_new;

   salc_ram #(.WIDTH(MAX_WAYS), .DEPTH(SETS)) u_valid_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.clear | ctl_cmd.commit),
      .wr_addr (wr_set),
      .wr_data (valid_wr),
      .rd_en   (ctl_cmd.accept),
      .rd_addr (set_idx),
      .rd_data (valid_rd)
   );

   salc_ram #(.WIDTH(MAX_WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.commit),
      .wr_addr (set_ff),
      .wr_data (tag_new),
      .rd_en   (ctl_cmd.accept),
      .rd_addr (set_idx),
      .rd_data (tag_rd)
   );

   salc_ram #(.WIDTH(MAX_WAYS*STAMP_W), .DEPTH(SETS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.commit),
      .wr_addr (set_ff),
      .wr_data (stamp_new),
      .rd_en   (ctl_cmd.accept),
      .rd_addr (set_idx),
      .rd_data (stamp_rd)
   );

   // ---------------- evaluate: match and age per way ----------------
   logic [MAX_WAYS-1:0] match_in, cand_in, empty_in;
   logic [STAMP_W-1:0]  age_in [MAX_WAYS];
   logic [MAX_WAYS-1:0] match_ff, cand_ff, empty_ff;
   logic [STAMP_W-1:0]  age_ff [MAX_WAYS];

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         match_in[w] = use_ff[w] & valid_rd[w] & (tag_rd[w*TAG_W +: TAG_W] == tag_ff);
         cand_in[w]  = use_ff[w] & valid_rd[w];
         empty_in[w] = use_ff[w] & ~valid_rd[w];
         age_in[w]   = clock_ff - stamp_rd[w*STAMP_W +: STAMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.eval) begin
         match_ff <= match_in;
         cand_ff  <= cand_in;
         empty_ff <= empty_in;
         age_ff   <= age_in;
      end
   end

   // ---------------- commit: pick way, build write-back rows ----------------
   logic [WAY_W-1:0]     hit_way, empty_way, victim_way, sel_way;
   logic [OUTCOME_W-1:0] sel_outcome;
   logic                 node_ok  [2*NP];
   logic [STAMP_W-1:0]   node_age [2*NP];
   logic [WAY_W-1:0]     node_idx [2*NP];

   // oldest valid way; on equal ages the lower way wins
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         if (i < MAX_WAYS) begin
            node_ok[NP+i]  = cand_ff[i];
            node_age[NP+i] = age_ff[i];
         end else begin
            node_ok[NP+i]  = 1'b0;
            node_age[NP+i] = '0;
         end
         node_idx[NP+i] = WAY_W'(i);
      end
      node_ok[0]  = 1'b0;
      node_age[0] = '0;
      node_idx[0] = '0;
      for (int n = NP - 1; n >= 1; n--) begin
         if (node_ok[2*n+1] && (!node_ok[2*n] || (node_age[2*n+1] > node_age[2*n]))) begin
            node_ok[n]  = node_ok[2*n+1];
            node_age[n] = node_age[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end else begin
            node_ok[n]  = node_ok[2*n];
            node_age[n] = node_age[2*n];
            node_idx[n] = node_idx[2*n];
         end
      end
      victim_way = node_idx[1];
   end

   always_comb begin
      hit_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match_ff[w]) hit_way = WAY_W'(w);   // lowest matching way
      end
      empty_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (empty_ff[w]) empty_way = WAY_W'(w); // highest empty way
      end

      if (|match_ff) begin
         sel_way     = hit_way;
         sel_outcome = OUT_HIT;
      end else if (|empty_ff) begin
         sel_way     = empty_way;
         sel_outcome = OUT_MISS;
      end else begin
         sel_way     = victim_way;
         sel_outcome = OUT_EVICT;
      end

      valid_new          = valid_rd;
      valid_new[sel_way] = 1'b1;
      tag_new            = tag_rd;
      tag_new[sel_way*TAG_W +: TAG_W] = tag_ff;
      stamp_new          = stamp_rd;
      stamp_new[sel_way*STAMP_W +: STAMP_W] = clock_ff;
   end

   // ---------------- totals and result register ----------------
   logic [TOTAL_W-1:0]   hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic                 rsp_valid_ff;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic                 rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else if (ctl_cmd.commit) begin
         case (sel_outcome)
            OUT_HIT: hit_cnt_ff <= hit_cnt_ff + TOTAL_W'(1);
            OUT_MISS: miss_cnt_ff <= miss_cnt_ff + TOTAL_W'(1);
            OUT_EVICT: begin
               miss_cnt_ff  <= miss_cnt_ff + TOTAL_W'(1);
               evict_cnt_ff <= evict_cnt_ff + TOTAL_W'(1);
            end
            default: ;
         endcase
      end else if (ctl_cmd.second) begin
         hit_cnt_ff <= hit_cnt_ff + TOTAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.commit || ctl_cmd.second) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.commit) begin
         rsp_outcome_ff <= sel_outcome;
         rsp_last_ff    <= (action_ff != ACT_MODIFY);
      end else if (ctl_cmd.second) begin
         rsp_outcome_ff <= OUT_HIT;
         rsp_last_ff    <= 1'b1;
      end
   end

   // counters only move when a result is loaded, so they double as its totals
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

   assign ctl_sts.clear_done = clr_last;
   assign ctl_sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign ctl_sts.modify     = (action_ff == ACT_MODIFY);
endmodule
`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_model_core.sv
// Set-associative cache model with LRU replacement. Each request (load, store or
// modify plus a byte address) is split into set index and tag using the offset
// and set-bit registers, looked up in the selected set, and answered with one
// result per lookup: hit, miss, or miss with eviction, with the running hit,
// miss and eviction totals. A modify gives two results, the second always a hit;
// "last" marks the final result of a request. After reset the valid bits are
// cleared one set per cycle, all 2**MAX_SET_BITS sets (64 by default), during
// which no request is taken; register writes are taken at any time. A load or
// store passes through accept with set read, tag compare and age compute, and
// LRU pick with write-back and result; a modify adds a step for its final hit.
// The next request is taken in the cycle after the last result is loaded into
// the output register, so one request is finished before the next is taken,
// and the wait grows while the response side holds off a waiting result.
`default_nettype none
module set_assoc_lru_cache_model_core #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   salc_req_if.sink   req_chan,
   salc_rsp_if.source rsp_chan,
   salc_csr_if.sink   csr_chan
);
   import salc_pkg::*;

   salc_cmd_type ctl_cmd;
   salc_sts_type ctl_sts;

   // sequencer: owns request-side ready and the per-lookup steps
   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .ctl_cmd   (ctl_cmd),
      .ctl_sts   (ctl_sts)
   );

   // datapath: registers, set memories, LRU pick, result register
   salc_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl_cmd            (ctl_cmd),
      .ctl_sts            (ctl_sts),
      .req_action         (req_chan.action),
      .req_address        (req_chan.address),
      .csr_valid          (csr_chan.valid),
      .csr_ready          (csr_chan.ready),
      .csr_index          (csr_chan.index),
      .csr_data           (csr_chan.data),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_outcome        (rsp_chan.outcome),
      .rsp_last           (rsp_chan.last),
      .rsp_hit_total      (rsp_chan.hit_total),
      .rsp_miss_total     (rsp_chan.miss_total),
      .rsp_eviction_total (rsp_chan.eviction_total)
   );
endmodule
`default_nettype wire

// File: hw/rtl/salc_checker.sv
// Port-level checker for the cache model core and its bind.
`default_nettype none
`include "assert_macros.svh"
module salc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [salc_pkg::OUTCOME_W-1:0] rsp_outcome,
   input wire logic                           rsp_last
);
   import salc_pkg::*;

   // a waiting result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no request is taken in the cycle after reset: the clear pass runs first
   `ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_ready)
   // one request at a time
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   // the first result of a modify is followed at once by its final hit
   `ASSERT_NEXT(a_modify_second, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && rsp_last && (rsp_outcome == OUT_HIT))
endmodule

bind set_assoc_lru_cache_model_core salc_checker u_salc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_outcome (rsp_chan.outcome),
   .rsp_last    (rsp_chan.last)
);
`default_nettype wire
